@@ hw/rtl/chtsb_pkg.sv @@
// ============================================================================
// chtsb_pkg
// Shared sizes, codes and control types for the sorted-bucket hash table.
// ============================================================================
package chtsb_pkg;

    localparam int NUM_BUCKETS  = 7;
    localparam int BUCKET_DEPTH = 8;
    localparam int KEY_WIDTH    = 16;

    localparam int REM_W       = $clog2(NUM_BUCKETS);
    localparam int IDX_W       = $clog2(BUCKET_DEPTH);
    localparam int POS_W       = $clog2(BUCKET_DEPTH + 1);
    localparam int ADDR_W      = REM_W + IDX_W;
    localparam int MEM_DEPTH   = NUM_BUCKETS * BUCKET_DEPTH;
    localparam int KEY_NIBBLES = (KEY_WIDTH + 3) / 4;
    localparam int NIB_CNT_W   = $clog2(KEY_NIBBLES);
    localparam int MOD_W       = REM_W + 4;
    localparam int OUT_W       = 16;

    typedef logic [1:0] op_t;
    localparam op_t OP_INSERT = 2'd0;
    localparam op_t OP_SEARCH = 2'd1;
    localparam op_t OP_REMOVE = 2'd2;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_MISSING = 2'd1;
    localparam status_t ST_FULL    = 2'd2;

    typedef struct packed {
        logic accept;
        logic mod_step;
        logic look;
        logic scan;
        logic fin;
        logic resp;
    } chtsb_cmd_t;

    typedef struct packed {
        logic mod_last;
        logic skip;
        logic scan_done;
        logic out_free;
    } chtsb_stat_t;

    // Remainder of a value below 16 * NUM_BUCKETS, by restoring subtraction
    // of the shifted bucket count.
    function automatic logic [REM_W-1:0] mod_small(input logic [MOD_W-1:0] v);
        logic [MOD_W-1:0] r;
        logic [MOD_W-1:0] d;
        r = v;
        for (int s = 3; s >= 0; s--) begin
            d = MOD_W'(NUM_BUCKETS) << s;
            if (r >= d) begin
                r = r - d;
            end
        end
        return r[REM_W-1:0];
    endfunction

endpackage

@@ hw/rtl/chtsb_ctrl.sv @@
// ============================================================================
// chtsb_ctrl
// Sequencer that steps one request through hashing, scan and response.
// ============================================================================
module chtsb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               ready,
    input  chtsb_pkg::chtsb_stat_t st,
    output chtsb_pkg::chtsb_cmd_t  cmd
);
    import chtsb_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MOD  = 6'b000010,
        S_LOOK = 6'b000100,
        S_SCAN = 6'b001000,
        S_FIN  = 6'b010000,
        S_RESP = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        ready      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                ready      = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (st.mod_last)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                cmd.look   = 1'b1;
                state_next = st.skip ? S_FIN : S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (st.scan_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                cmd.resp = 1'b1;
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hw/rtl/chtsb_dp.sv @@
// ============================================================================
// chtsb_dp
// Datapath: key hashing, bucket store, fill counts, scan and output register.
// ============================================================================
module chtsb_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  chtsb_pkg::chtsb_cmd_t         cmd,
    output chtsb_pkg::chtsb_stat_t        st,
    input  chtsb_pkg::op_t                op_in,
    input  logic [chtsb_pkg::KEY_WIDTH-1:0] key_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [chtsb_pkg::OUT_W-1:0]   out_data
);
    import chtsb_pkg::*;

    logic [KEY_WIDTH-1:0] store_mem [MEM_DEPTH];
    logic [KEY_WIDTH-1:0] rdata_reg;
    logic [ADDR_W-1:0]    raddr;
    logic                 we;
    logic [ADDR_W-1:0]    waddr;
    logic [KEY_WIDTH-1:0] wdata;

    logic [POS_W-1:0]     fill_reg [NUM_BUCKETS];
    logic [POS_W-1:0]     fill_cur;

    op_t                  op_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [NIB_CNT_W-1:0] nib_cnt_reg;
    logic [REM_W-1:0]     bucket_reg;
    logic [POS_W-1:0]     n_reg;
    logic [POS_W-1:0]     ridx_reg;
    logic [POS_W-1:0]     cidx_reg;
    logic                 cval_reg;
    logic                 found_reg;
    logic [POS_W-1:0]     at_reg;
    logic [KEY_WIDTH-1:0] carry_reg;

    logic                 hit_reg;
    status_t              status_reg;
    logic [POS_W-1:0]     pos_reg;

    logic                 out_valid_reg;
    logic [OUT_W-1:0]     out_data_reg;

    logic [3:0]           nibble;
    logic                 is_insert;
    logic                 is_search;
    logic                 is_remove;
    logic                 bucket_full;
    logic                 load_out;

    assign nibble      = key_reg[{nib_cnt_reg, 2'b00} +: 4];
    assign fill_cur    = fill_reg[bucket_reg];
    assign is_insert   = (op_reg == OP_INSERT);
    assign is_search   = (op_reg == OP_SEARCH);
    assign is_remove   = (op_reg == OP_REMOVE);
    assign bucket_full = (n_reg >= POS_W'(BUCKET_DEPTH));
    assign load_out    = cmd.resp && st.out_free;

    assign st.mod_last  = (nib_cnt_reg == '0);
    assign st.skip      = (is_insert && (fill_cur >= POS_W'(BUCKET_DEPTH)))
                          || !(is_insert || is_search || is_remove);
    assign st.scan_done = !cval_reg && (ridx_reg >= n_reg);
    assign st.out_free  = !out_valid_reg || out_ready;

    assign raddr = {bucket_reg, ridx_reg[IDX_W-1:0]};

    // Write port: shifting during the scan, tail entry at the finish.
    always_comb
    begin
        we    = 1'b0;
        waddr = {bucket_reg, cidx_reg[IDX_W-1:0]};
        wdata = key_reg;
        if (cmd.scan && cval_reg)
        begin
            if (is_insert)
            begin
                if (found_reg)
                begin
                    we    = 1'b1;
                    wdata = carry_reg;
                end
                else if (rdata_reg >= key_reg)
                begin
                    we    = 1'b1;
                    wdata = key_reg;
                end
            end
            else if (is_remove && found_reg)
            begin
                we    = 1'b1;
                waddr = {bucket_reg, IDX_W'(cidx_reg - 1'b1)};
                wdata = rdata_reg;
            end
        end
        else if (cmd.fin && is_insert && !bucket_full)
        begin
            we    = 1'b1;
            waddr = {bucket_reg, n_reg[IDX_W-1:0]};
            wdata = found_reg ? carry_reg : key_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[waddr] <= wdata;
        end
        rdata_reg <= store_mem[raddr];
    end

    // Request registers and scan bookkeeping.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg      <= op_in;
            key_reg     <= key_in;
            nib_cnt_reg <= NIB_CNT_W'(KEY_NIBBLES - 1);
            bucket_reg  <= '0;
        end
        if (cmd.mod_step)
        begin
            bucket_reg  <= mod_small({bucket_reg, nibble});
            nib_cnt_reg <= nib_cnt_reg - 1'b1;
        end
        if (cmd.look)
        begin
            n_reg     <= fill_cur;
            ridx_reg  <= '0;
            found_reg <= 1'b0;
        end
        if (cmd.scan)
        begin
            if (ridx_reg < n_reg)
            begin
                cidx_reg <= ridx_reg;
                ridx_reg <= ridx_reg + 1'b1;
            end
            if (cval_reg)
            begin
                if (is_insert)
                begin
                    if (found_reg || (rdata_reg >= key_reg))
                    begin
                        carry_reg <= rdata_reg;
                    end
                    if (!found_reg && (rdata_reg >= key_reg))
                    begin
                        found_reg <= 1'b1;
                        at_reg    <= cidx_reg;
                    end
                end
                else if (!found_reg && (rdata_reg == key_reg))
                begin
                    found_reg <= 1'b1;
                    at_reg    <= cidx_reg;
                end
            end
        end
        if (cmd.fin)
        begin
            hit_reg    <= 1'b0;
            status_reg <= ST_MISSING;
            pos_reg    <= '0;
            if (is_insert)
            begin
                if (bucket_full)
                begin
                    status_reg <= ST_FULL;
                end
                else
                begin
                    hit_reg    <= 1'b1;
                    status_reg <= ST_OK;
                    pos_reg    <= found_reg ? at_reg : n_reg;
                end
            end
            else if ((is_search || is_remove) && found_reg)
            begin
                hit_reg    <= 1'b1;
                status_reg <= ST_OK;
                pos_reg    <= at_reg;
            end
        end
        if (load_out)
        begin
            out_data_reg <= OUT_W'({pos_reg, bucket_reg, status_reg, hit_reg});
        end
    end

    // Control flags and fill counts.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cval_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int b = 0; b < NUM_BUCKETS; b++)
            begin
                fill_reg[b] <= '0;
            end
        end
        else
        begin
            if (cmd.look)
            begin
                cval_reg <= 1'b0;
            end
            else if (cmd.scan)
            begin
                cval_reg <= (ridx_reg < n_reg);
            end
            if (cmd.fin)
            begin
                if (is_insert && !bucket_full)
                begin
                    fill_reg[bucket_reg] <= n_reg + 1'b1;
                end
                else if (is_remove && found_reg)
                begin
                    fill_reg[bucket_reg] <= n_reg - 1'b1;
                end
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ hw/rtl/chained_hash_table_sorted_buckets.sv @@
// ============================================================================
// chained_hash_table_sorted_buckets
// Hash table of seven sorted buckets with insert, search and remove requests.
// ============================================================================
//
//  Channel   Direction  Signals                        Word contents
//  --------  ---------  -----------------------------  -------------------------
//  request   in         s_tvalid s_tready s_tdata      key; s_tuser carries op
//                       s_tuser
//  result    out        m_tvalid m_tready m_tdata      hit, status, bucket,
//                                                      position
//
// A request passes through hashing, lookup, bucket scan, finish and response
// before the next one is accepted; an insert into a full bucket or an unused
// op code skips the scan. The scan walks the bucket one entry a cycle through
// the single read port of the key store while the write port shifts entries
// behind it. Hashing the key modulo the bucket count takes one nibble a cycle.
// After reset all buckets are empty; no clearing pass is needed.
// A finished result waits in the output register while m_tready is low; the
// block still takes one more request and works it through, then holds its
// result back until the waiting word is taken.
//
// Bucket entries are kept in ascending order. Insert places the key in front of
// the first entry that is not smaller, so equal keys sit side by side. Search
// and remove act on the first equal entry, and remove closes the gap by moving
// the later entries down one place, including when the head entry goes.
//
module chained_hash_table_sorted_buckets (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] key
    input  logic [1:0]  s_tuser,   // [1:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [0] hit, [2:1] status, [5:3] bucket,
                                   // [9:6] position, [15:10] zero
);
    import chtsb_pkg::*;

    chtsb_cmd_t  cmd;
    chtsb_stat_t st;

    // The sequencer decides what happens in each cycle.
    chtsb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .ready    (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // The datapath holds the store, the fill counts and the result word.
    chtsb_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .op_in     (s_tuser),
        .key_in    (s_tdata[KEY_WIDTH-1:0]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    // One request is worked on at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in progress");

    // A hit is reported exactly when the status is ok.
    a_hit_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[0] == (m_tdata[2:1] == ST_OK)))
        else $error("hit flag disagrees with status");

    // Bucket and position stay inside the table.
    a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[5:3] < REM_W'(NUM_BUCKETS))
                      && (m_tdata[9:6] <= POS_W'(BUCKET_DEPTH))))
        else $error("bucket or position out of range");

endmodule
